[rtl/acsfd_pkg.sv]
// Shared constants, types and decode functions for the status frame decoder.
package acsfd_pkg;

    localparam int MAX_BODY_DEFAULT = 1024;

    localparam int DATA_W      = 8;
    localparam int CFG_ADDR_W  = 2;
    localparam int FRAME_LEN_W = 11;
    localparam int M_TDATA_W   = 40;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_TEMP_LOW  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_TEMP_HIGH = CFG_ADDR_W'(1);

    localparam logic [7:0] SYNC_A     = 8'hF4;
    localparam logic [7:0] SYNC_B     = 8'hF5;
    localparam logic [7:0] TAIL_B     = 8'hFB;
    localparam logic [7:0] CMD_ACK    = 8'd101;
    localparam logic [7:0] CMD_STATUS = 8'd102;
    localparam logic [7:0] FAN_LOW    = 8'd12;
    localparam logic [7:0] FAN_MED    = 8'd14;
    localparam logic [7:0] FAN_HIGH   = 8'd16;

    localparam int MIN_DECODE_LEN = 20;
    localparam int MIN_TEMP_LEN   = 21;
    localparam int MIN_SWING_LEN  = 36;

    // byte positions inside a frame, start pair at 0 and 1
    localparam int POS_CMD      = 13;
    localparam int POS_FAN      = 16;
    localparam int POS_MODE     = 18;
    localparam int POS_SETPOINT = 19;
    localparam int POS_ROOM     = 20;
    localparam int POS_SWING    = 35;

    localparam logic [7:0] TEMP_LOW_RESET  = 8'd8;
    localparam logic [7:0] TEMP_HIGH_RESET = 8'd45;
    localparam logic [7:0] SETPOINT_RESET  = 8'd24;

    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_OTHER  = 2'd2;

    localparam logic [2:0] MODE_OFF  = 3'd0;
    localparam logic [2:0] MODE_FAN  = 3'd1;
    localparam logic [2:0] MODE_HEAT = 3'd2;
    localparam logic [2:0] MODE_COOL = 3'd3;
    localparam logic [2:0] MODE_DRY  = 3'd4;
    localparam logic [2:0] MODE_AUTO = 3'd5;

    localparam logic [1:0] FANSPD_AUTO = 2'd0;
    localparam logic [1:0] FANSPD_LOW  = 2'd1;
    localparam logic [1:0] FANSPD_MED  = 2'd2;
    localparam logic [1:0] FANSPD_HIGH = 2'd3;

    localparam logic [7:0] POWER_MASK = 8'b0000_1000;
    localparam logic [7:0] SWING_MASK = 8'b1100_0000;

    typedef struct packed {
        logic       swing_on;
        logic [7:0] room_temp;
        logic [7:0] target_temp;
        logic [1:0] fan_speed;
        logic [2:0] op_mode;
        logic       power_on;
        logic [FRAME_LEN_W-1:0] frame_length;
        logic [1:0] frame_kind;
    } result_t;

    function automatic logic [2:0] mode_from_nibble(input logic [3:0] nib);
        logic [2:0] m;
        unique case (nib)
            4'd1:    m = MODE_FAN;
            4'd3:    m = MODE_HEAT;
            4'd5:    m = MODE_COOL;
            4'd7:    m = MODE_DRY;
            default: m = MODE_AUTO;
        endcase
        return m;
    endfunction

    function automatic logic [1:0] fan_from_code(input logic [7:0] code);
        logic [1:0] f;
        unique case (code)
            FAN_LOW:  f = FANSPD_LOW;
            FAN_MED:  f = FANSPD_MED;
            FAN_HIGH: f = FANSPD_HIGH;
            default:  f = FANSPD_AUTO;
        endcase
        return f;
    endfunction

endpackage

[rtl/ac_status_frame_decoder.sv]
// Status frame decoder: byte hunt, frame capture, decode and two-entry result buffer.
// A result enters the result buffer when its tail byte is accepted.
// Throughput: one byte per cycle while s_tready is high; the per-byte compare, capture and decode sit
// between the kept-state registers and a two-entry result buffer.
// s_tready drops only while both result entries are full.
// Reset (aresetn low, synchronous): hunting, count and kept values to defaults,
// thresholds to 8 and 45, result buffer empty. Capture bytes are not reset.
module ac_status_frame_decoder
    import acsfd_pkg::*;
#(
    parameter int MAX_BODY = MAX_BODY_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,   // [7:0] rx_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [10:0] frame_length, [11] power_on,
                                             // [14:12] op_mode, [16:15] fan_speed,
                                             // [24:17] target_temp, [32:25] room_temp,
                                             // [33] swing_on, rest zero
    output logic [1:0]            m_tuser,   // [1:0] frame_kind
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [7:0]            cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_BODY + 4);
    localparam logic [CNT_W-1:0] CNT_START = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_BODY + 2);
    localparam logic [CNT_W-1:0] CNT_TAIL_MIN = CNT_W'(4);

    logic [7:0] temp_low_reg, temp_high_reg;

    logic             in_frame_reg, in_frame_next;
    logic [7:0]       prev_reg, prev_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [7:0] cmd_cap_reg, fan_cap_reg, mode_cap_reg;
    logic [7:0] setp_cap_reg, room_cap_reg, swing_cap_reg;

    logic       power_reg, power_next;
    logic [2:0] mode_reg, mode_next;
    logic [1:0] fan_reg, fan_next;
    logic [7:0] setp_reg, setp_next;
    logic [7:0] room_reg, room_next;
    logic       swing_reg, swing_next;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;

    logic       accept, pop, push;
    logic [7:0] b;
    logic [CNT_W-1:0] cnt_inc;
    logic       frame_end;
    logic [7:0] cmd_eff, fan_eff, mode_eff, setp_eff, room_eff, swing_eff;
    logic [1:0] kind;
    result_t    res_new;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !skid_valid_reg;
    assign pop      = out_valid_reg && m_tready;
    assign b        = s_tdata;
    assign cnt_inc  = cnt_reg + CNT_W'(1);

    assign frame_end = in_frame_reg && (cnt_inc >= CNT_TAIL_MIN)
                       && (prev_reg == SYNC_A) && (b == TAIL_B);
    assign push = accept && frame_end;

    // the tail byte itself may land on a capture position
    assign cmd_eff   = (cnt_reg == CNT_W'(POS_CMD))      ? b : cmd_cap_reg;
    assign fan_eff   = (cnt_reg == CNT_W'(POS_FAN))      ? b : fan_cap_reg;
    assign mode_eff  = (cnt_reg == CNT_W'(POS_MODE))     ? b : mode_cap_reg;
    assign setp_eff  = (cnt_reg == CNT_W'(POS_SETPOINT)) ? b : setp_cap_reg;
    assign room_eff  = (cnt_reg == CNT_W'(POS_ROOM))     ? b : room_cap_reg;
    assign swing_eff = (cnt_reg == CNT_W'(POS_SWING))    ? b : swing_cap_reg;

    always_comb begin
        power_next = power_reg;
        mode_next  = mode_reg;
        fan_next   = fan_reg;
        setp_next  = setp_reg;
        room_next  = room_reg;
        swing_next = swing_reg;
        priority if (cnt_inc < CNT_W'(MIN_DECODE_LEN)) begin
            kind = KIND_OTHER;
        end else if (cmd_eff == CMD_ACK) begin
            kind = KIND_ACK;
        end else if (cmd_eff != CMD_STATUS) begin
            kind = KIND_OTHER;
        end else begin
            kind       = KIND_STATUS;
            power_next = |(mode_eff & POWER_MASK);
            mode_next  = power_next ? mode_from_nibble(mode_eff[7:4]) : MODE_OFF;
            fan_next   = fan_from_code(fan_eff);
            if (cnt_inc >= CNT_W'(MIN_TEMP_LEN)) begin
                if (setp_eff >= temp_low_reg && setp_eff <= temp_high_reg) begin
                    setp_next = setp_eff;
                end
                if (room_eff >= temp_low_reg && room_eff <= temp_high_reg) begin
                    room_next = room_eff;
                end
            end
            if (cnt_inc >= CNT_W'(MIN_SWING_LEN)) begin
                swing_next = |(swing_eff & SWING_MASK);
            end
        end
    end

    always_comb begin
        res_new.frame_kind   = kind;
        res_new.frame_length = FRAME_LEN_W'(cnt_inc);
        res_new.power_on     = power_next;
        res_new.op_mode      = mode_next;
        res_new.fan_speed    = fan_next;
        res_new.target_temp  = setp_next;
        res_new.room_temp    = room_next;
        res_new.swing_on     = swing_next;
    end

    always_comb begin
        in_frame_next = in_frame_reg;
        prev_next     = prev_reg;
        cnt_next      = cnt_reg;
        if (!in_frame_reg) begin
            if (prev_reg == SYNC_A && b == SYNC_B) begin
                in_frame_next = 1'b1;
                cnt_next      = CNT_START;
            end
            prev_next = b;
        end else if (frame_end || cnt_inc > CNT_LIMIT) begin
            // end of frame, or overlong body dropped
            in_frame_next = 1'b0;
            prev_next     = '0;
            cnt_next      = '0;
        end else begin
            cnt_next  = cnt_inc;
            prev_next = b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_low_reg   <= TEMP_LOW_RESET;
            temp_high_reg  <= TEMP_HIGH_RESET;
            in_frame_reg   <= 1'b0;
            prev_reg       <= '0;
            cnt_reg        <= '0;
            power_reg      <= 1'b0;
            mode_reg       <= MODE_OFF;
            fan_reg        <= FANSPD_AUTO;
            setp_reg       <= SETPOINT_RESET;
            room_reg       <= '0;
            swing_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_TEMP_LOW:  temp_low_reg  <= cfg_wdata;
                    REG_TEMP_HIGH: temp_high_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                in_frame_reg <= in_frame_next;
                prev_reg     <= prev_next;
                cnt_reg      <= cnt_next;
            end
            if (push) begin
                power_reg <= power_next;
                mode_reg  <= mode_next;
                fan_reg   <= fan_next;
                setp_reg  <= setp_next;
                room_reg  <= room_next;
                swing_reg <= swing_next;
            end
            if (pop || !out_valid_reg) begin
                out_valid_reg  <= skid_valid_reg || push;
                skid_valid_reg <= skid_valid_reg && push;
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // capture bytes and result payload: no reset needed
    always_ff @(posedge aclk) begin
        if (accept && in_frame_reg) begin
            if (cnt_reg == CNT_W'(POS_CMD))      cmd_cap_reg   <= b;
            if (cnt_reg == CNT_W'(POS_FAN))      fan_cap_reg   <= b;
            if (cnt_reg == CNT_W'(POS_MODE))     mode_cap_reg  <= b;
            if (cnt_reg == CNT_W'(POS_SETPOINT)) setp_cap_reg  <= b;
            if (cnt_reg == CNT_W'(POS_ROOM))     room_cap_reg  <= b;
            if (cnt_reg == CNT_W'(POS_SWING))    swing_cap_reg <= b;
        end
        if (pop || !out_valid_reg) begin
            out_reg <= skid_valid_reg ? skid_reg : res_new;
            if (skid_valid_reg && push) skid_reg <= res_new;
        end else if (push) begin
            skid_reg <= res_new;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.frame_kind;
    assign m_tdata  = M_TDATA_W'({out_reg.swing_on, out_reg.room_temp,
                                  out_reg.target_temp, out_reg.fan_speed,
                                  out_reg.op_mode, out_reg.power_on,
                                  out_reg.frame_length});

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output entry empty");

    a_count_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        in_frame_reg |-> (cnt_reg >= CNT_START && cnt_reg <= CNT_LIMIT))
        else $error("byte count out of range inside a frame");

    a_count_hunting: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_frame_reg |-> cnt_reg == '0)
        else $error("byte count not cleared while hunting");

    a_status_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_STATUS)
            |-> m_tdata[FRAME_LEN_W-1:0] >= FRAME_LEN_W'(MIN_DECODE_LEN))
        else $error("status item shorter than decode minimum");

endmodule

[sim/tb_ac_status_frame_decoder.sv]
// Self-checking testbench for the air-conditioner status frame decoder.
module tb_ac_status_frame_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import acsfd_pkg::*;

    localparam int BODY_LIMIT = MAX_BODY_DEFAULT;
    localparam int RANDOM_ITEMS = 650;
    localparam int RANDOM_REPORTS = 48;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int unsigned RUN_LIMIT_NS = 5_000_000;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = CFG_ADDR_W'(3);

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [7:0]            cfg_wdata = '0;

    ac_status_frame_decoder #(.MAX_BODY(BODY_LIMIT)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // traffic shaping
    bit gaps_on = 1'b1;
    bit stall_on = 1'b1;
    bit hold_on = 1'b0;

    int mismatch_count = 0;
    int reports_seen = 0;
    int bytes_accepted = 0;

    // decoder state as the testbench tracks it
    logic [7:0] thr_low = TEMP_LOW_RESET;
    logic [7:0] thr_high = TEMP_HIGH_RESET;
    bit         rx_in_frame = 1'b0;
    logic [7:0] rx_prev = '0;
    int         rx_pos = 0;
    logic [7:0] cap_cmd, cap_fan, cap_mode, cap_setpoint, cap_room, cap_swing;
    logic       kept_power = 1'b0;
    logic [2:0] kept_mode = MODE_OFF;
    logic [1:0] kept_fan = FANSPD_AUTO;
    logic [7:0] kept_setpoint = SETPOINT_RESET;
    logic [7:0] kept_room = '0;
    logic       kept_swing = 1'b0;

    result_t expected_reports[$];

    // Advance the tracked decoder by one received byte; queue a report at a frame end.
    function automatic void track_rx_byte(input logic [7:0] b);
        result_t r;
        int len;
        if (!rx_in_frame) begin
            if (rx_prev == SYNC_A && b == SYNC_B) begin
                rx_in_frame = 1'b1;
                rx_pos = 2;
            end
            rx_prev = b;
            return;
        end
        case (rx_pos)
            POS_CMD:      cap_cmd = b;
            POS_FAN:      cap_fan = b;
            POS_MODE:     cap_mode = b;
            POS_SETPOINT: cap_setpoint = b;
            POS_ROOM:     cap_room = b;
            POS_SWING:    cap_swing = b;
            default:      ;
        endcase
        rx_pos++;
        if (rx_pos >= 4 && rx_prev == SYNC_A && b == TAIL_B) begin
            len = rx_pos;
            r.frame_kind = KIND_OTHER;
            if (len >= MIN_DECODE_LEN && cap_cmd == CMD_ACK) begin
                r.frame_kind = KIND_ACK;
            end else if (len >= MIN_DECODE_LEN && cap_cmd == CMD_STATUS) begin
                r.frame_kind = KIND_STATUS;
                kept_power = |(cap_mode & POWER_MASK);
                if (!kept_power) begin
                    kept_mode = MODE_OFF;
                end else begin
                    case (cap_mode[7:4])
                        4'd1:    kept_mode = MODE_FAN;
                        4'd3:    kept_mode = MODE_HEAT;
                        4'd5:    kept_mode = MODE_COOL;
                        4'd7:    kept_mode = MODE_DRY;
                        default: kept_mode = MODE_AUTO;
                    endcase
                end
                if (cap_fan == FAN_LOW)       kept_fan = FANSPD_LOW;
                else if (cap_fan == FAN_MED)  kept_fan = FANSPD_MED;
                else if (cap_fan == FAN_HIGH) kept_fan = FANSPD_HIGH;
                else                          kept_fan = FANSPD_AUTO;
                if (len >= MIN_TEMP_LEN) begin
                    if (cap_setpoint >= thr_low && cap_setpoint <= thr_high)
                        kept_setpoint = cap_setpoint;
                    if (cap_room >= thr_low && cap_room <= thr_high)
                        kept_room = cap_room;
                end
                if (len >= MIN_SWING_LEN)
                    kept_swing = |(cap_swing & SWING_MASK);
            end
            r.frame_length = FRAME_LEN_W'(len);
            r.power_on = kept_power;
            r.op_mode = kept_mode;
            r.fan_speed = kept_fan;
            r.target_temp = kept_setpoint;
            r.room_temp = kept_room;
            r.swing_on = kept_swing;
            expected_reports.insert(expected_reports.size(), r);
            rx_in_frame = 1'b0;
            rx_prev = '0;
            rx_pos = 0;
            return;
        end
        if (rx_pos - 2 > BODY_LIMIT) begin
            // overlong body: drop, and the dropped bytes cannot start a new frame
            rx_in_frame = 1'b0;
            rx_prev = '0;
            rx_pos = 0;
            return;
        end
        rx_prev = b;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // report checker and receiver side ready control
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
                $error("unexpected report: frame_length %0d, frame_kind %0d",
                       m_tdata[10:0], m_tuser);
                mismatch_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("frame_kind", want.frame_kind, m_tuser);
                check_field("frame_length", want.frame_length, m_tdata[10:0]);
                check_field("power_on", want.power_on, m_tdata[11]);
                check_field("op_mode", want.op_mode, m_tdata[14:12]);
                check_field("fan_speed", want.fan_speed, m_tdata[16:15]);
                check_field("target_temp", want.target_temp, m_tdata[24:17]);
                check_field("room_temp", want.room_temp, m_tdata[32:25]);
                check_field("swing_on", want.swing_on, m_tdata[33]);
            end
        end
        m_tready <= !hold_on && !(stall_on && $urandom_range(99) < 18);
    end

    task automatic send_byte(input logic [7:0] b);
        while (gaps_on && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_accepted++;
        track_rx_byte(b);
    endtask

    // Start pair, body with the captured fields in place, tail pair.
    task automatic send_frame(input int len, input logic [7:0] cmd, input logic [7:0] fan,
                              input logic [7:0] mode, input logic [7:0] setp,
                              input logic [7:0] room, input logic [7:0] swing);
        logic [7:0] v;
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        for (int p = 2; p < len - 2; p++) begin
            case (p)
                POS_CMD:      v = cmd;
                POS_FAN:      v = fan;
                POS_MODE:     v = mode;
                POS_SETPOINT: v = setp;
                POS_ROOM:     v = room;
                POS_SWING:    v = swing;
                default:      v = 8'($urandom_range(0, 8'hF3));
            endcase
            send_byte(v);
        end
        send_byte(SYNC_A);
        send_byte(TAIL_B);
    endtask

    // sender stops until every report is back and the block has gone quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == REG_TEMP_LOW)
            thr_low = val;
        else if (idx == REG_TEMP_HIGH)
            thr_high = val;
    endtask

    task automatic set_window(input logic [7:0] lo, input logic [7:0] hi);
        settle();
        write_reg(REG_SPARE_2, 8'($urandom));
        write_reg(REG_TEMP_LOW, lo);
        write_reg(REG_TEMP_HIGH, hi);
        write_reg(REG_SPARE_3, 8'($urandom));
        cfg_we <= 1'b0;
    endtask

    task automatic test_frame_kinds();
        // noise while hunting, then F4 F4 F5 sync into a minimum frame
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_A);
        send_byte(TAIL_B);
        send_byte(SYNC_A);
        send_frame(4, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_frame(19, CMD_ACK, FAN_LOW, 8'h58, 8'd22, 8'd25, 8'hC0);
        send_frame(20, CMD_ACK, FAN_LOW, 8'h58, 8'd22, 8'd25, 8'hC0);
        send_frame(19, CMD_STATUS, FAN_LOW, 8'h58, 8'd22, 8'd25, 8'hC0);
        // decoded, but too short for temperatures
        send_frame(20, CMD_STATUS, FAN_MED, 8'h18, 8'd30, 8'd31, 8'hC0);
        send_frame(21, CMD_STATUS, FAN_HIGH, 8'h38, 8'd22, 8'd27, 8'hC0);
        send_frame(36, CMD_STATUS, FAN_HIGH, 8'h58, 8'd23, 8'd26, 8'h80);
        send_frame(36, CMD_STATUS, FAN_LOW, 8'h78, 8'd24, 8'd28, 8'h40);
        // unknown mode nibble and fan code, temps out of range
        send_frame(40, CMD_STATUS, 8'd99, 8'hA8, 8'd50, 8'd3, 8'h00);
        send_frame(36, CMD_STATUS, FAN_MED, 8'h98, 8'd25, 8'd25, 8'hC0);
        // power off, swing bits clear
        send_frame(36, CMD_STATUS, FAN_MED, 8'h57, 8'd26, 8'd26, 8'h3F);
        send_frame(30, 8'h00, FAN_HIGH, 8'hFF, 8'd40, 8'd40, 8'hFF);
        send_frame(36, 8'hFF, FAN_HIGH, 8'hFF, 8'd40, 8'd40, 8'hFF);
        settle();
    endtask

    task automatic test_long_frames();
        send_frame(BODY_LIMIT + 3, CMD_STATUS, FAN_LOW, 8'h38, 8'd20, 8'd21, 8'hC0);
        // body one byte past the limit: dropped without a report
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        for (int p = 2; p < BODY_LIMIT + 2; p++)
            send_byte(8'($urandom_range(0, 8'hF3)));
        send_byte(SYNC_A);
        // the F4 above was dropped, so this F5 must not sync
        send_byte(SYNC_B);
        send_byte(TAIL_B);
        send_frame(4, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        settle();
    endtask

    task automatic test_temp_window();
        set_window(8'd0, 8'd255);
        send_frame(21, CMD_STATUS, FAN_LOW, 8'h58, 8'd0, 8'd255, 8'h00);
        send_frame(21, CMD_STATUS, FAN_LOW, 8'h58, 8'd255, 8'd0, 8'h00);
        // inverted range: nothing accepted
        set_window(8'd255, 8'd0);
        send_frame(36, CMD_STATUS, FAN_MED, 8'h58, 8'd100, 8'd0, 8'hC0);
        send_frame(36, CMD_STATUS, FAN_MED, 8'h58, 8'd255, 8'd255, 8'hC0);
        set_window(8'd30, 8'd30);
        send_frame(21, CMD_STATUS, FAN_HIGH, 8'h38, 8'd30, 8'd31, 8'h00);
        send_frame(21, CMD_STATUS, FAN_HIGH, 8'h38, 8'd29, 8'd30, 8'h00);
        set_window(TEMP_LOW_RESET, TEMP_HIGH_RESET);
        send_frame(21, CMD_STATUS, FAN_HIGH, 8'h38, 8'd7, 8'd45, 8'h00);
        send_frame(21, CMD_STATUS, FAN_HIGH, 8'h38, 8'd8, 8'd46, 8'h00);
        settle();
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        // receiver holds off on its own while the sender keeps offering items
        fork
            begin
                hold_on <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_on <= 1'b0;
            end
        join_none
        repeat (20) send_frame(4, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        settle();
        gaps_on = 1'b1;
        repeat (10)
            send_frame($urandom_range(4, 24), CMD_STATUS, FAN_LOW, 8'($urandom),
                       8'($urandom_range(0, 60)), 8'($urandom_range(0, 60)), 8'h00);
        settle();
    endtask

    task automatic send_random_frame();
        int len;
        int pick;
        logic [7:0] cmd, fan, mode, setp, room;
        pick = $urandom_range(99);
        if (pick < 80)      len = $urandom_range(20, 40);
        else if (pick < 90) len = $urandom_range(4, 19);
        else                len = $urandom_range(41, 90);
        pick = $urandom_range(99);
        if (pick < 70)      cmd = CMD_STATUS;
        else if (pick < 80) cmd = CMD_ACK;
        else                cmd = 8'($urandom);
        case ($urandom_range(4))
            0:       fan = FAN_LOW;
            1:       fan = FAN_MED;
            2:       fan = FAN_HIGH;
            default: fan = 8'($urandom);
        endcase
        mode = 8'($urandom);
        if ($urandom_range(1) == 1)
            mode[7:4] = 4'(2 * $urandom_range(4) + 1);
        setp = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 60));
        room = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 60));
        send_frame(len, cmd, fan, mode, setp, room, 8'($urandom));
    endtask

    task automatic test_random_traffic();
        int first_byte, first_report, phase, pick;
        logic [7:0] lo, hi;
        first_byte = bytes_accepted;
        first_report = reports_seen;
        phase = 0;
        while (bytes_accepted - first_byte < RANDOM_ITEMS ||
               reports_seen - first_report < RANDOM_REPORTS) begin
            // quiet stretch with no gaps and no stalls
            gaps_on = !(phase >= 20 && phase < 40);
            stall_on = gaps_on;
            if (phase % 8 == 7) begin
                lo = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(0, 30));
                hi = ($urandom_range(3) == 0) ? 8'd255 : 8'($urandom_range(20, 60));
                if ($urandom_range(9) == 0)
                    set_window(hi, lo);
                else
                    set_window(lo, hi);
            end
            pick = $urandom_range(99);
            if (pick < 75) begin
                send_random_frame();
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 6))
                    send_byte(($urandom_range(9) < 3) ? SYNC_A : 8'($urandom));
            end else begin
                // start pair with no tail: runs on into whatever follows
                send_byte(SYNC_A);
                send_byte(SYNC_B);
                repeat ($urandom_range(3, 15)) send_byte(8'($urandom));
            end
            phase++;
        end
        gaps_on = 1'b1;
        stall_on = 1'b1;
        settle();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_frame_kinds();
        test_long_frames();
        test_temp_window();
        test_backpressure();
        test_random_traffic();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $error("run limit reached with %0d reports outstanding", expected_reports.size());
        $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/acsfd_pkg.sv
rtl/ac_status_frame_decoder.sv
sim/tb_ac_status_frame_decoder.sv
